// ===== rtl/core/slpd_pkg.sv =====
// slpd_pkg: shared types and constants of the sequential/loop prefetch detector
// no dependencies
`timescale 1ns / 1ps
package slpd_pkg;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_RANDOM = 2'd0;
   localparam mode_type MODE_SEQ    = 2'd1;
   localparam mode_type MODE_BUILD  = 2'd2;
   localparam mode_type MODE_LOOP   = 2'd3;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_SEQ_TH   = 2'd0;
   localparam csr_index_type CSR_LOOP_TH  = 2'd1;
   localparam csr_index_type CSR_SPEEDUP  = 2'd2;
   localparam csr_index_type CSR_DEG_LIM  = 2'd3;

   localparam logic [3:0]  SEQ_TH_RST   = 4'd4;
   localparam logic [3:0]  LOOP_TH_RST  = 4'd2;
   localparam logic [3:0]  SPEEDUP_RST  = 4'd2;
   localparam logic [15:0] DEG_LIM_RST  = 16'd256;
   localparam logic [3:0]  RUN_MAX      = 4'd15;

endpackage

// ===== rtl/core/slpd_table.sv =====
// slpd_table: keyed table with valid bits and a one-entry-per-cycle search unit
// depends on nothing; instantiated by the top level
`timescale 1ns / 1ps
module slpd_table #(
   parameter int DEPTH = 64,
   parameter int DW    = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     scan_go,
   input  logic [31:0]              scan_key,
   output logic                     scan_done,
   output logic                     hit,
   output logic [$clog2(DEPTH)-1:0] hit_idx,
   output logic [DW-1:0]            hit_data,
   output logic                     free_ok,
   output logic [$clog2(DEPTH)-1:0] free_idx,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_idx,
   input  logic [31:0]              wr_key,
   input  logic [DW-1:0]            wr_data
);
   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [31+DW:0]  mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [AW-1:0]   ptr_ff;
   logic            active_ff;
   logic            rd_vld_ff;
   logic [AW-1:0]   rd_idx_ff;
   logic [31+DW:0]  rd_ent_ff;
   logic            hit_ff, free_ff, done_ff;
   logic [AW-1:0]   hit_idx_ff, free_idx_ff;
   logic [DW-1:0]   hit_data_ff;
   logic            ent_hit;

   assign ent_hit = valid_ff[rd_idx_ff] && (rd_ent_ff[31+DW:DW] == scan_key);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= {wr_key, wr_data};
      end
      rd_ent_ff <= mem[ptr_ff];
      rd_idx_ff <= ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         ptr_ff    <= '0;
         active_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
         hit_ff    <= 1'b0;
         free_ff   <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         rd_vld_ff <= active_ff;
         done_ff   <= rd_vld_ff && (rd_idx_ff == LAST);
         if (scan_go) begin
            ptr_ff    <= '0;
            active_ff <= 1'b1;
            hit_ff    <= 1'b0;
            free_ff   <= 1'b0;
         end else begin
            if (active_ff) begin
               ptr_ff <= ptr_ff + 1'b1;
               if (ptr_ff == LAST) begin
                  active_ff <= 1'b0;
               end
            end
            if (rd_vld_ff) begin
               if (ent_hit && !hit_ff) begin
                  hit_ff <= 1'b1;
               end
               if (!valid_ff[rd_idx_ff] && !free_ff) begin
                  free_ff <= 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff && ent_hit && !hit_ff) begin
         hit_idx_ff  <= rd_idx_ff;
         hit_data_ff <= rd_ent_ff[DW-1:0];
      end
      if (rd_vld_ff && !valid_ff[rd_idx_ff] && !free_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
   end

   assign scan_done = done_ff;
   assign hit       = hit_ff;
   assign hit_idx   = hit_idx_ff;
   assign hit_data  = hit_data_ff;
   assign free_ok   = free_ff;
   assign free_idx  = free_idx_ff;
endmodule

// ===== rtl/core/sequential_loop_prefetch_detector.sv =====
// sequential_loop_prefetch_detector: top level, run tracking, mode sequencer
// depends on slpd_pkg and slpd_table
`timescale 1ns / 1ps
// usage
//   a request word (req_start, req_count) is taken when start is high and
//   busy is low. one result word is shown on the rsp_ ports for one cycle,
//   marked by rsp_valid; the receiver cannot stall it.
//   a request that breaks the run goes from idle straight to the update
//   state. a request that continues the run first searches both tables
//   (sequential and loop) in parallel, one entry per cycle through a
//   single read port each, then enters the update state.
//   busy stays high through the update state; the result strobe follows it.
//   csr_ writes are taken at any time (csr_ready is tied high) but are
//   only meant while no request is in flight.
//   reset restores register defaults, clears run state and all table
//   valid bits at once; no clearing pass is needed.
module sequential_loop_prefetch_detector #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_start,
   input  logic [15:0] req_count,
   output logic        rsp_valid,
   output logic [31:0] rsp_prefetch_end,
   output logic [1:0]  rsp_pattern,
   output logic [31:0] rsp_loop_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  slpd_pkg::csr_index_type csr_index,
   input  logic [15:0] csr_wdata
);
   import slpd_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   state_type   state_ff, state_in;
   logic [3:0]  seq_th_ff, loop_th_ff, speedup_ff;
   logic [15:0] deg_lim_ff;
   mode_type    mode_ff, mode_in;
   logic [3:0]  run_cnt_ff, run_cnt_in;
   logic [31:0] run_start_ff, run_start_in;
   logic [31:0] run_end_ff, run_end_in;
   logic [31:0] pref_to_ff, pref_to_in;
   logic [15:0] degree_ff, degree_in;
   logic [31:0] loop_len_ff, loop_len_in;
   logic [31:0] start_ff;
   logic [15:0] cnt_ff;
   logic [31:0] req_end_ff;
   logic        cont_ff;
   logic [19:0] prod_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_end_ff, range_in;
   logic [1:0]  rsp_pat_ff;
   logic [31:0] rsp_len_ff;

   logic        accept;
   logic [15:0] cnt_eff;
   logic [32:0] end_sum;

   logic        s_done, s_hit, s_free, l_done, l_hit, l_free;
   logic [AW-1:0] s_idx, s_fidx, l_idx, l_fidx;
   logic [31:0] s_end;
   logic [63:0] l_data;
   logic [31:0] l_end, l_ext;
   logic        s_we, l_we;
   logic [AW-1:0] s_widx, l_widx;
   logic [31:0] s_wdata;
   logic [63:0] l_wdata;
   logic        scan_go;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign cnt_eff   = (req_count == 16'd0) ? 16'd1 : req_count;
   assign end_sum   = {1'b0, req_start} + {17'd0, cnt_eff} - 33'd1;
   assign scan_go   = accept && (({1'b0, run_end_ff} + 33'd1) == {1'b0, req_start});
   assign l_end     = l_data[63:32];
   assign l_ext     = l_data[31:0];

   slpd_table #(.DEPTH(TABLE_DEPTH), .DW(32)) u_seq_tbl (
      .clock(clock), .reset(reset), .scan_go(scan_go), .scan_key(run_start_ff),
      .scan_done(s_done), .hit(s_hit), .hit_idx(s_idx), .hit_data(s_end),
      .free_ok(s_free), .free_idx(s_fidx),
      .wr_en(s_we), .wr_idx(s_widx), .wr_key(run_start_ff), .wr_data(s_wdata)
   );

   slpd_table #(.DEPTH(TABLE_DEPTH), .DW(64)) u_loop_tbl (
      .clock(clock), .reset(reset), .scan_go(scan_go), .scan_key(run_start_ff),
      .scan_done(l_done), .hit(l_hit), .hit_idx(l_idx), .hit_data(l_data),
      .free_ok(l_free), .free_idx(l_fidx),
      .wr_en(l_we), .wr_idx(l_widx), .wr_key(run_start_ff), .wr_data(l_wdata)
   );

   function automatic logic [15:0] clamp_deg(input logic [19:0] d, input logic [15:0] lim);
      clamp_deg = (d > {4'd0, lim}) ? lim : d[15:0];
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {17'd0, b};
      sat_add = s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   always_comb begin
      logic done;
      logic grow;
      logic [3:0] rc;
      done = 1'b0;
      grow = 1'b0;
      rc = (run_cnt_ff < RUN_MAX) ? run_cnt_ff + 4'd1 : RUN_MAX;
      state_in     = state_ff;
      mode_in      = mode_ff;
      run_cnt_in   = run_cnt_ff;
      run_start_in = run_start_ff;
      run_end_in   = run_end_ff;
      pref_to_in   = pref_to_ff;
      degree_in    = degree_ff;
      loop_len_in  = loop_len_ff;
      range_in     = 32'd0;
      s_we = 1'b0; s_widx = s_idx; s_wdata = req_end_ff;
      l_we = 1'b0; l_widx = l_idx; l_wdata = l_data;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = scan_go ? ST_SCAN : ST_EXEC;
            end
         end
         ST_SCAN: begin
            if (s_done && l_done) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            if (!cont_ff) begin
               mode_in = MODE_RANDOM; run_cnt_in = 4'd1; run_start_in = start_ff;
               run_end_in = req_end_ff; pref_to_in = 32'd0; degree_in = 16'd0;
            end else begin
               case (mode_ff) inside
                  MODE_RANDOM: begin
                     run_cnt_in = rc;
                     if (rc == loop_th_ff) begin
                        if (l_hit && req_end_ff < l_end) begin
                           mode_in = MODE_LOOP;
                           pref_to_in = l_end; range_in = l_end;
                           loop_len_in = l_end - run_start_ff + 32'd1;
                           done = 1'b1;
                        end else if (s_hit && req_end_ff < s_end) begin
                           mode_in = MODE_BUILD;
                           if (!l_hit && l_free) begin
                              l_we = 1'b1; l_widx = l_fidx; l_wdata = {req_end_ff, s_end};
                           end
                           loop_len_in = req_end_ff - run_start_ff + 32'd1;
                           degree_in = clamp_deg({4'd0, cnt_ff}, deg_lim_ff);
                           range_in = sat_add(req_end_ff, degree_in);
                           pref_to_in = range_in;
                           done = 1'b1;
                        end
                     end
                     if (!done && rc >= seq_th_ff) begin
                        mode_in = MODE_SEQ;
                        if (!s_hit && s_free) begin
                           s_we = 1'b1; s_widx = s_fidx;
                        end
                        degree_in = clamp_deg({4'd0, cnt_ff}, deg_lim_ff);
                        range_in = sat_add(req_end_ff, degree_in);
                        pref_to_in = range_in;
                     end
                  end
                  MODE_SEQ: begin
                     s_we = s_hit;
                     grow = 1'b1;
                  end
                  MODE_BUILD, MODE_LOOP: begin
                     if (l_hit && (mode_ff == MODE_BUILD || start_ff > l_end)) begin
                        l_we = 1'b1;
                        if (start_ff <= l_ext) begin
                           l_wdata = {req_end_ff, l_ext};
                           loop_len_in = req_end_ff - run_start_ff + 32'd1;
                        end else begin
                           l_wdata = {l_end, req_end_ff};
                        end
                     end
                     if (mode_ff == MODE_BUILD) begin
                        grow = 1'b1;
                     end else if (req_end_ff > pref_to_ff) begin
                        degree_in = clamp_deg((degree_ff == 16'd0) ? {4'd0, cnt_ff} : prod_ff,
                                              deg_lim_ff);
                        range_in = sat_add(req_end_ff, degree_in);
                        pref_to_in = range_in;
                     end
                  end
                  default: ;
               endcase
               if (grow && req_end_ff > pref_to_ff) begin
                  degree_in = clamp_deg(prod_ff, deg_lim_ff);
                  range_in = sat_add(req_end_ff, degree_in);
                  pref_to_in = range_in;
               end
               run_end_in = req_end_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         start_ff   <= req_start;
         cnt_ff     <= cnt_eff;
         req_end_ff <= end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
         cont_ff    <= scan_go;
         prod_ff    <= degree_ff * speedup_ff;
      end
      rsp_end_ff <= range_in;
      rsp_pat_ff <= mode_in;
      rsp_len_ff <= loop_len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seq_th_ff    <= SEQ_TH_RST;
         loop_th_ff   <= LOOP_TH_RST;
         speedup_ff   <= SPEEDUP_RST;
         deg_lim_ff   <= DEG_LIM_RST;
         mode_ff      <= MODE_RANDOM;
         run_cnt_ff   <= '0;
         run_start_ff <= '0;
         run_end_ff   <= '0;
         pref_to_ff   <= '0;
         degree_ff    <= '0;
         loop_len_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         run_cnt_ff   <= run_cnt_in;
         run_start_ff <= run_start_in;
         run_end_ff   <= run_end_in;
         pref_to_ff   <= pref_to_in;
         degree_ff    <= degree_in;
         loop_len_ff  <= loop_len_in;
         rsp_valid_ff <= (state_ff == ST_EXEC);
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SEQ_TH:  seq_th_ff  <= csr_wdata[3:0];
               CSR_LOOP_TH: loop_th_ff <= csr_wdata[3:0];
               CSR_SPEEDUP: speedup_ff <= csr_wdata[3:0];
               CSR_DEG_LIM: deg_lim_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_prefetch_end = rsp_end_ff;
   assign rsp_pattern      = rsp_pat_ff;
   assign rsp_loop_length  = rsp_len_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("accepted word without busy");
   a_random_no_prefetch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pattern == MODE_RANDOM) |-> (rsp_prefetch_end == 32'd0))
      else $error("prefetch issued in random mode");
endmodule
